### hw/rtl/set_assoc_lru_cache_tags_assert.svh
// assertion macros shared by the cache tag block
`ifndef SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH

// condition implies consequence in the same cycle
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/salc_pkg.sv
package salc_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;
  localparam int SET_OUT_W = 6;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic lookup;
    logic update;
  } salc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
  } salc_sts_t;

endpackage

### hw/rtl/salc_in_if.sv
interface salc_in_if;
  logic                         valid;
  logic                         ready;
  logic [salc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

### hw/rtl/salc_out_if.sv
interface salc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [salc_pkg::WAY_OUT_W-1:0] way_used;
  logic [salc_pkg::SET_OUT_W-1:0] set_used;
  logic [salc_pkg::CNT_W-1:0]     hit_total;
  logic [salc_pkg::CNT_W-1:0]     miss_total;

  modport source (output valid, output hit, output way_used, output set_used,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input set_used,
                  input hit_total, input miss_total, output ready);
endinterface

### hw/rtl/set_assoc_lru_cache_tags.sv
// flow: an input transfer reads the set RAM; the lookup state then writes the updated row
// back and loads the result; a new access is taken only when idle, result free or draining
// reset: asynchronous active low; a clearing pass then runs over every row of the set
// RAM, during which no input is taken
module set_assoc_lru_cache_tags #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int TAG_BITS    = 20,
  parameter int ADDR_BITS   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  salc_in_if.sink    in_i,
  salc_out_if.source out_o
);

  salc_pkg::salc_cmd_t cmd;
  salc_pkg::salc_sts_t sts;

  // sequencing
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tag lookup and replacement
  salc_datapath #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .TAG_BITS    (TAG_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .address_i    (in_i.address),
    .hit_o        (out_o.hit),
    .way_used_o   (out_o.way_used),
    .set_used_o   (out_o.set_used),
    .hit_total_o  (out_o.hit_total),
    .miss_total_o (out_o.miss_total)
  );

endmodule

### hw/rtl/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                     wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                     rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/salc_ctrl.sv
`include "set_assoc_lru_cache_tags_assert.svh"

module salc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output salc_pkg::salc_cmd_t cmd_o,
  input  salc_pkg::salc_sts_t sts_i
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // ready only when idle and the result register is free or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == ST_CLEAR);
    cmd_o.lookup     = accept;
    cmd_o.update     = (state_q == ST_LOOKUP);
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `SALC_ASSERT_NEXT(a_accept_to_lookup, accept, state_q == ST_LOOKUP, "accept without lookup")
  `SALC_ASSERT_NOW(a_no_ready_clear, state_q == ST_CLEAR, !in_ready_o, "ready during clear")
  `SALC_ASSERT_NOW(a_lookup_out_free, state_q == ST_LOOKUP, !out_valid_q, "result reg busy")

endmodule

### hw/rtl/salc_datapath.sv
module salc_datapath #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int TAG_BITS    = 20,
  parameter int ADDR_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  salc_pkg::salc_cmd_t               cmd_i,
  output salc_pkg::salc_sts_t               sts_o,
  input  logic [salc_pkg::ADDR_W-1:0]       address_i,
  output logic                              hit_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]    way_used_o,
  output logic [salc_pkg::SET_OUT_W-1:0]    set_used_o,
  output logic [salc_pkg::CNT_W-1:0]        hit_total_o,
  output logic [salc_pkg::CNT_W-1:0]        miss_total_o
);

  localparam int WIDX      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_BITS  = $clog2(SETS + 1) - 1;
  localparam int OFF_BITS  = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int ROW_W     = WAYS * (TAG_BITS + 1 + WIDX);
  localparam logic [63:0] AMASK64 =
    (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SET_IDX_W-1:0] SET_MASK =
    SET_IDX_W'((64'd1 << SET_BITS) - 64'd1);

  logic [salc_pkg::ADDR_W-1:0] addr_m, set_sh, tag_sh;
  logic [SET_IDX_W-1:0]        set_in, set_q, clr_q;
  logic [TAG_BITS-1:0]         tag_in, tag_q;

  logic [ROW_W-1:0] rd_row, wr_row, upd_row, clr_row;
  logic             wr_en;
  logic [SET_IDX_W-1:0] wr_addr;

  logic [WAYS-1:0][TAG_BITS-1:0] r_tags, n_tags, c_tags;
  logic [WAYS-1:0]               r_vld, n_vld, c_vld;
  logic [WAYS-1:0][WIDX-1:0]     r_ord, n_ord, c_ord;

  logic            hit;
  logic [WIDX-1:0] way, pos;
  logic            found;

  logic                             hit_q;
  logic [salc_pkg::WAY_OUT_W-1:0]   way_q;
  logic [salc_pkg::SET_OUT_W-1:0]   set_out_q;
  logic [salc_pkg::CNT_W-1:0]       hit_cnt_q, miss_cnt_q;
  logic [31:0]                      set32, way32;

  // address split
  assign addr_m = address_i & AMASK64[salc_pkg::ADDR_W-1:0];
  assign set_sh = addr_m >> OFF_BITS;
  assign tag_sh = addr_m >> (OFF_BITS + SET_BITS);
  assign set_in = set_sh[SET_IDX_W-1:0] & SET_MASK;
  assign tag_in = tag_sh[TAG_BITS-1:0];

  // capture the access at transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // row fields
  assign {r_ord, r_vld, r_tags} = rd_row;

  // tag match and victim choice
  always_comb begin
    hit   = 1'b0;
    way   = r_ord[0];
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && r_vld[i] && (r_tags[i] == tag_q)) begin
        hit = 1'b1;
        way = WIDX'(i);
      end
    end
  end

  // fill the victim way on a miss and move the used way to the most recent position
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && (r_ord[i] == way)) begin
        found = 1'b1;
        pos   = WIDX'(i);
      end
    end
    n_tags = r_tags;
    n_vld  = r_vld;
    if (!hit) begin
      n_tags[way] = tag_q;
      n_vld[way]  = 1'b1;
    end
    for (int i = 0; i < WAYS - 1; i++) begin
      n_ord[i] = (WIDX'(i) < pos) ? r_ord[i] : r_ord[i + 1];
    end
    n_ord[WAYS-1] = way;
  end

  assign upd_row = {n_ord, n_vld, n_tags};

  // clearing row: nothing valid, ways in order
  always_comb begin
    c_tags = '0;
    c_vld  = '0;
    for (int i = 0; i < WAYS; i++) begin
      c_ord[i] = WIDX'(i);
    end
  end

  assign clr_row = {c_ord, c_vld, c_tags};

  // write port mux
  assign wr_en   = cmd_i.clear_step || cmd_i.update;
  assign wr_addr = cmd_i.clear_step ? clr_q : set_q;
  assign wr_row  = cmd_i.clear_step ? clr_row : upd_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_row),
    .rd_en_i   (cmd_i.lookup),
    .rd_addr_i (set_in),
    .rd_data_o (rd_row)
  );

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_q == SET_IDX_W'(SETS - 1));

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.update) begin
      if (hit) begin
        hit_cnt_q <= hit_cnt_q + 1'b1;
      end else begin
        miss_cnt_q <= miss_cnt_q + 1'b1;
      end
    end
  end

  assign set32 = 32'(set_q);
  assign way32 = 32'(way);

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q     <= hit;
      way_q     <= way32[salc_pkg::WAY_OUT_W-1:0];
      set_out_q <= set32[salc_pkg::SET_OUT_W-1:0];
    end
  end

  assign hit_o        = hit_q;
  assign way_used_o   = way_q;
  assign set_used_o   = set_out_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule

### test/salc_tb_if.sv
`timescale 1ns / 1ps

// shared stimulus record for the address channel
package salc_tb_pkg;
  typedef struct {
    logic [31:0] address;
    logic        known;   // expected result typed in the table
    logic        hit;
    logic [1:0]  way;
  } access_row_t;
endpackage

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NWAYS = 4;
  localparam int NSETS = 64;
  localparam int RANDOM_ACCESSES = 1100;

  // lookup result as seen on the output channel
  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [5:0]  set;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  salc_in_if  in_ch ();
  salc_out_if out_ch ();

  set_assoc_lru_cache_tags dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow cache state
  logic [19:0] tags [NSETS][NWAYS];
  logic        valids [NSETS][NWAYS];
  logic [1:0]  lru_order [NSETS][NWAYS];
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;

  lookup_t pending_lookups [$];
  int      errors = 0;
  logic    hold_off = 1'b0;

  function automatic lookup_t predict_lookup(logic [31:0] addr);
    lookup_t r;
    logic [5:0]  s;
    logic [19:0] t;
    int pos;
    s = addr[11:6];
    t = addr[31:12];
    r.hit = 1'b0;
    r.way = 2'd0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!r.hit && valids[s][w] && tags[s][w] == t) begin
        r.hit = 1'b1;
        r.way = w[1:0];
      end
    end
    if (r.hit) begin
      hit_cnt = hit_cnt + 1;
    end else begin
      r.way = lru_order[s][0];
      tags[s][r.way] = t;
      valids[s][r.way] = 1'b1;
      miss_cnt = miss_cnt + 1;
    end
    // move way to most recently used slot
    pos = 0;
    for (int i = NWAYS - 1; i >= 0; i--) begin
      if (lru_order[s][i] == r.way) pos = i;
    end
    for (int i = pos; i < NWAYS - 1; i++) begin
      lru_order[s][i] = lru_order[s][i + 1];
    end
    lru_order[s][NWAYS - 1] = r.way;
    r.set = s;
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  // directed table: extremes, fill of one set, eviction, rehit
  salc_tb_pkg::access_row_t dir_rows [$];

  function automatic salc_tb_pkg::access_row_t row(logic [31:0] a, logic k, logic h,
                                                   logic [1:0] w);
    salc_tb_pkg::access_row_t r;
    r.address = a;
    r.known = k;
    r.hit = h;
    r.way = w;
    return r;
  endfunction

  initial begin
    dir_rows.push_back(row(32'h0000_0000, 1'b1, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h0000_003f, 1'b1, 1'b1, 2'd0));
    dir_rows.push_back(row(32'hffff_ffff, 1'b1, 1'b0, 2'd0));
    dir_rows.push_back(row(32'hffff_ffc0, 1'b1, 1'b1, 2'd0));
    dir_rows.push_back(row(32'h0000_1000, 1'b1, 1'b0, 2'd1));
    dir_rows.push_back(row(32'h0000_2000, 1'b1, 1'b0, 2'd2));
    dir_rows.push_back(row(32'h0000_3000, 1'b1, 1'b0, 2'd3));
    dir_rows.push_back(row(32'h0000_4000, 1'b1, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h0000_1004, 1'b0, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h0000_0000, 1'b0, 1'b0, 2'd0));
    dir_rows.push_back(row(32'haaaa_aaaa, 1'b0, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h5555_5555, 1'b0, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h8000_0800, 1'b0, 1'b0, 2'd0));
    dir_rows.push_back(row(32'h8000_0800, 1'b0, 1'b0, 2'd0));
  end

  // sender: bursts with random gaps
  task automatic send_access(logic [31:0] addr);
    in_ch.valid <= 1'b1;
    in_ch.address <= addr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_input(int n);
    in_ch.valid <= 1'b0;
    in_ch.address <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  logic [31:0] hot_tags [8];

  function automatic logic [31:0] random_address();
    int k;
    k = $urandom_range(0, 9);
    // mostly a small tag pool over few sets so hits and evictions happen
    if (k < 8) return {hot_tags[$urandom_range(0, 7)][19:0],
                       6'($urandom_range(0, 3)), 6'($urandom)};
    return $urandom;
  endfunction

  initial begin
    int burst;
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.address = '0;
    for (int i = 0; i < 8; i++) hot_tags[i] = $urandom;
    // shadow reset
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        valids[s][w] = 1'b0;
        tags[s][w] = '0;
        lru_order[s][w] = w[1:0];
      end
    end
    hit_cnt = '0;
    miss_cnt = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      lookup_t e;
      e = predict_lookup(dir_rows[i].address);
      if (dir_rows[i].known) begin
        e.hit = dir_rows[i].hit;
        e.way = dir_rows[i].way;
      end
      pending_lookups.push_back(e);
      send_access(dir_rows[i].address);
    end
    in_ch.valid <= 1'b0;
    // pause until drained
    while (pending_lookups.size() != 0) @(negedge clk_i);

    // random part, with one long receiver hold-off
    for (int n = 0; n < RANDOM_ACCESSES; ) begin
      if (n >= 300 && !held) begin
        held = 1'b1;
        hold_off = 1'b1;
      end
      if (n >= 600 && !drained) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (pending_lookups.size() != 0) @(negedge clk_i);
      end
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < RANDOM_ACCESSES; b++, n++) begin
        logic [31:0] a;
        a = random_address();
        pending_lookups.push_back(predict_lookup(a));
        send_access(a);
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
    in_ch.valid <= 1'b0;

    while (pending_lookups.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // receiver stall pattern, plus one long hold-off
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (phase < 20) out_ch.ready <= 1'b1;
      else if (phase < 40) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= 1'($urandom_range(0, 1));
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        lookup_t e;
        e = pending_lookups.pop_front();
        if (out_ch.hit !== e.hit) begin
          $error("hit: expected %0d got %0d", e.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.way_used !== e.way) begin
          $error("way_used: expected %0d got %0d", e.way, out_ch.way_used);
          errors++;
        end
        if (out_ch.set_used !== e.set) begin
          $error("set_used: expected %0d got %0d", e.set, out_ch.set_used);
          errors++;
        end
        if (out_ch.hit_total !== e.hits) begin
          $error("hit_total: expected %0d got %0d", e.hits, out_ch.hit_total);
          errors++;
        end
        if (out_ch.miss_total !== e.misses) begin
          $error("miss_total: expected %0d got %0d", e.misses, out_ch.miss_total);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
